// ===== src/key_debounce_long_press_defines.svh =====
// assertion macros shared by the key debounce block
// no dependencies; included by the top module, which carries the assertions
`ifndef KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KDLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define KDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kdlp_pkg.sv =====
// types and constants of the key debounce / long press block
// no dependencies; imported by every module and interface of the block
package kdlp_pkg;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd2;
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 8'd50;

  localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_COUNT   = 2'd0,
    CFG_LONG_PRESS_COUNT = 2'd1,
    CFG_ACTIVE_LOW       = 2'd2
  } kdlp_cfg_idx_t;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_PRESSED = 2'd1,
    PHASE_HELD    = 2'd2
  } kdlp_phase_t;

  // debouncer status for the current tick
  typedef struct packed {
    logic key_down;
    logic fire;
  } kdlp_deb_stat_t;

  // keypad machine results for the current tick
  typedef struct packed {
    logic              released;
    logic              request_manual;
    logic              long_press;
    logic [MODE_W-1:0] new_display_mode;
  } kdlp_keypad_res_t;

endpackage

// ===== src/kdlp_in_if.sv =====
// input request channel: raw key level and display mode
// depends on kdlp_pkg
interface kdlp_in_if
  import kdlp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              key_level;
  logic [MODE_W-1:0] display_mode;

  modport source (output valid, output key_level, output display_mode, input ready);
  modport sink (input valid, input key_level, input display_mode, output ready);
endinterface

// ===== src/kdlp_out_if.sv =====
// result channel: debounced key status and key events
// depends on kdlp_pkg
interface kdlp_out_if
  import kdlp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              key_down;
  logic              changed;
  logic              released;
  logic              request_manual;
  logic              long_press;
  logic [MODE_W-1:0] new_display_mode;

  modport source (output valid, output key_down, output changed, output released,
                  output request_manual, output long_press, output new_display_mode,
                  input ready);
  modport sink (input valid, input key_down, input changed, input released,
                input request_manual, input long_press, input new_display_mode,
                output ready);
endinterface

// ===== src/kdlp_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on kdlp_pkg
interface kdlp_cfg_if
  import kdlp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/key_debounce_long_press.sv =====
// top level of the key debounce / long press block
// depends on kdlp_pkg, the three channel interfaces, kdlp_debounce, kdlp_keypad
// and key_debounce_long_press_defines.svh
//
// One request carries one sampled tick of the raw key level plus the current
// display mode, and yields exactly one result. A request is first captured in
// an input register; once the output register is free, the debouncer and the
// keypad phase machine update their state from it and the result lands in the
// output register, and a new request is taken every cycle as long as the
// result side keeps up. A
// waiting result in the output register does not block the input register:
// one more request is taken and held until the output frees. Press and
// release use separate counters that are not cleared by the opposite level;
// key_down is the debounced flag after the tick, changed marks a debounced
// press or release edge or a repeated held event, released reports a key
// release (with request_manual when the display was in auto mode), and
// long_press fires when the count of held events reaches long_press_count,
// with new_display_mode giving the mode to switch to (manual from auto or
// other, else auto). Configuration (debounce_count, long_press_count,
// active_low) is written through the cfg channel, which is always ready; an
// index past the last register is ignored. Write it only while idle.
module key_debounce_long_press
  import kdlp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  kdlp_in_if.sink    in_chan,
  kdlp_out_if.source out_chan,
  kdlp_cfg_if.sink   cfg_chan
);

`include "key_debounce_long_press_defines.svh"

  // configuration registers
  logic [CNT_W-1:0] debounce_count_r;
  logic [CNT_W-1:0] long_press_count_r;
  logic             active_low_r;

  // input register
  logic              s1_valid_r;
  logic              s1_level_r;
  logic [MODE_W-1:0] s1_mode_r;

  // output register
  logic              out_valid_r;
  logic              out_key_down_r;
  logic              out_changed_r;
  logic              out_released_r;
  logic              out_req_manual_r;
  logic              out_long_press_r;
  logic [MODE_W-1:0] out_new_mode_r;

  logic             advance;
  logic             step_en;
  kdlp_deb_stat_t   deb_stat;
  kdlp_keypad_res_t kp_res;

  // output register frees when empty or when its result is taken
  assign advance = !out_valid_r || out_chan.ready;
  assign step_en = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_count_r <= DEBOUNCE_RESET;
      long_press_count_r <= LONG_PRESS_RESET;
      active_low_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_DEBOUNCE_COUNT:   debounce_count_r <= cfg_chan.data;
        CFG_LONG_PRESS_COUNT: long_press_count_r <= cfg_chan.data;
        CFG_ACTIVE_LOW:       active_low_r <= cfg_chan.data[0];
        default:              ;
      endcase
    end
  end

  // input register: load on acceptance, drain when the step runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_level_r <= in_chan.key_level;
      s1_mode_r <= in_chan.display_mode;
    end
  end

  kdlp_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (step_en),
    .key_level      (s1_level_r),
    .active_low     (active_low_r),
    .debounce_count (debounce_count_r),
    .stat           (deb_stat)
  );

  kdlp_keypad u_keypad (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (step_en),
    .stat             (deb_stat),
    .display_mode     (s1_mode_r),
    .long_press_count (long_press_count_r),
    .res              (kp_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_key_down_r <= deb_stat.key_down;
      out_changed_r <= deb_stat.fire;
      out_released_r <= kp_res.released;
      out_req_manual_r <= kp_res.request_manual;
      out_long_press_r <= kp_res.long_press;
      out_new_mode_r <= kp_res.new_display_mode;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.key_down = out_key_down_r;
  assign out_chan.changed = out_changed_r;
  assign out_chan.released = out_released_r;
  assign out_chan.request_manual = out_req_manual_r;
  assign out_chan.long_press = out_long_press_r;
  assign out_chan.new_display_mode = out_new_mode_r;

  // a release is a debounced edge back to not pressed
  `KDLP_ASSERT_NOW(a_release_edge, clk, rst_n, out_valid_r && out_released_r, out_changed_r && !out_key_down_r && !out_long_press_r, "release without a debounced release edge")

  // a long press only comes from a held, pressed key
  `KDLP_ASSERT_NOW(a_long_press_held, clk, rst_n, out_valid_r && out_long_press_r, out_changed_r && out_key_down_r, "long press while key not held")

  // manual request only on a release, new mode only on a long press
  `KDLP_ASSERT_NOW(a_side_fields, clk, rst_n, out_valid_r, (!out_req_manual_r || out_released_r) && (out_long_press_r || (out_new_mode_r == MODE_AUTO)), "event side fields without their event")

  // a request waiting behind a stalled result is kept
  `KDLP_ASSERT_NEXT(a_stall_keeps, clk, rst_n, s1_valid_r && out_valid_r && !out_chan.ready, s1_valid_r && out_valid_r, "request lost during output stall")

endmodule

// ===== src/kdlp_debounce.sv =====
// press / release debouncer with separate counters and a debounced flag
// depends on kdlp_pkg
module kdlp_debounce
  import kdlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             key_level,
  input  logic             active_low,
  input  logic [CNT_W-1:0] debounce_count,
  output kdlp_deb_stat_t   stat
);

  logic [CNT_W-1:0] press_cnt_r, press_cnt_nxt;
  logic [CNT_W-1:0] rel_cnt_r, rel_cnt_nxt;
  logic             flag_r, flag_nxt;
  logic [CNT_W-1:0] press_inc, rel_inc;
  logic             pressed_now;
  logic             fire;

  assign pressed_now = key_level != active_low;
  assign press_inc = press_cnt_r + 8'd1;
  assign rel_inc = rel_cnt_r + 8'd1;

  // opposite level does not clear a partial count
  always_comb begin
    press_cnt_nxt = press_cnt_r;
    rel_cnt_nxt = rel_cnt_r;
    flag_nxt = flag_r;
    fire = 1'b0;
    if (pressed_now) begin
      if (press_inc >= debounce_count) begin
        press_cnt_nxt = '0;
        flag_nxt = 1'b1;
        fire = 1'b1;
      end else begin
        press_cnt_nxt = press_inc;
      end
    end else if (flag_r) begin
      if (rel_inc >= debounce_count) begin
        rel_cnt_nxt = '0;
        flag_nxt = 1'b0;
        fire = 1'b1;
      end else begin
        rel_cnt_nxt = rel_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_cnt_r <= '0;
      rel_cnt_r <= '0;
      flag_r <= 1'b0;
    end else if (en) begin
      press_cnt_r <= press_cnt_nxt;
      rel_cnt_r <= rel_cnt_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign stat.key_down = flag_nxt;
  assign stat.fire = fire;

endmodule

// ===== src/kdlp_keypad.sv =====
// keypad phase machine: release reports and long press counting
// depends on kdlp_pkg
module kdlp_keypad
  import kdlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  kdlp_deb_stat_t    stat,
  input  logic [MODE_W-1:0] display_mode,
  input  logic [CNT_W-1:0]  long_press_count,
  output kdlp_keypad_res_t  res
);

  kdlp_phase_t      phase_r, phase_nxt;
  logic [CNT_W-1:0] hold_r, hold_nxt;
  logic [CNT_W-1:0] hold_inc;
  logic             rel;
  logic             lp;

  assign hold_inc = hold_r + 8'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (stat.fire) begin
      unique case (phase_r)
        PHASE_PRESSED: phase_nxt = stat.key_down ? PHASE_HELD : PHASE_IDLE;
        PHASE_HELD:    phase_nxt = stat.key_down ? PHASE_HELD : PHASE_IDLE;
        default:       phase_nxt = stat.key_down ? PHASE_PRESSED : PHASE_IDLE;
      endcase
    end
  end

  // hold count and events
  always_comb begin
    hold_nxt = hold_r;
    rel = 1'b0;
    lp = 1'b0;
    if (stat.fire) begin
      unique case (phase_r)
        PHASE_PRESSED: begin
          if (!stat.key_down) begin
            rel = 1'b1;
          end else begin
            hold_nxt = 8'd1;
          end
        end
        PHASE_HELD: begin
          if (!stat.key_down) begin
            rel = 1'b1;
          end else if (hold_inc >= long_press_count) begin
            hold_nxt = '0;
            lp = 1'b1;
          end else begin
            hold_nxt = hold_inc;
          end
        end
        default: hold_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      hold_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign res.released = rel;
  assign res.request_manual = rel && (display_mode == MODE_AUTO);
  assign res.long_press = lp;
  assign res.new_display_mode =
    !lp ? MODE_AUTO :
    ((display_mode == MODE_AUTO) || (display_mode == MODE_OTHER)) ? MODE_MANUAL : MODE_AUTO;

endmodule
